// File: rtl/hcilp_pkg.sv
// ----------------------------------------------------------------------------
// hcilp_pkg
// Shared types, codes and constants of the colour/icon line parser.
// ----------------------------------------------------------------------------
package hcilp_pkg;

  localparam int MaxLine = 4096;
  localparam int PosW    = 12;
  localparam int PosMaxI = (MaxLine - 1 < 4095) ? (MaxLine - 1) : 4095;
  localparam logic [PosW-1:0] PosMax = PosW'(PosMaxI);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [1:0] ChanMax = 2'd3;

  typedef enum logic [1:0] {
    KIND_ICON = 2'd0,
    KIND_MSG  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK_MSG   = 2'd0,
    STAT_OK_NOMSG = 2'd1,
    STAT_ERR      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RES_BARE = 2'd0,
    RES_DQ   = 2'd1,
    RES_SQ   = 2'd2
  } resume_e;

  typedef enum logic [8:0] {
    ST_START = 9'b000000001,
    ST_LOW   = 9'b000000010,
    ST_HIGH  = 9'b000000100,
    ST_ICON  = 9'b000001000,
    ST_BARE  = 9'b000010000,
    ST_DQ    = 9'b000100000,
    ST_SQ    = 9'b001000000,
    ST_ESC   = 9'b010000000,
    ST_MSG   = 9'b100000000
  } pstate_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    status_e         status;
    logic [PosW-1:0] pos;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [1:0]      channels;
    logic            has_icon;
  } item_t;

  // bit 4: digit valid, bits 3:0: nibble
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

// File: rtl/hcilp_front.sv
// ----------------------------------------------------------------------------
// hcilp_front
// Character parser: takes one character per cycle while the queue is not full,
// tracks the line state and pushes icon, message and done transactions into the queue.
// ----------------------------------------------------------------------------
module hcilp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               q_full_i,
  output logic               push_o,
  output hcilp_pkg::item_t   push_item_o
);

  hcilp_pkg::pstate_e          state_q, state_d;
  hcilp_pkg::resume_e          resume_q, resume_d;
  logic [1:0]                  count_q, count_d;
  logic [7:0]                  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [hcilp_pkg::PosW-1:0]  off_q, off_d;
  logic                        err_q, err_d;
  logic [hcilp_pkg::PosW-1:0]  err_off_q, err_off_d;
  logic                        msg_q, msg_d;
  logic                        icon_q, icon_d;

  logic       accept;
  logic [4:0] hex;
  logic       blank;
  logic       emit;
  hcilp_pkg::item_t item;

  assign in_ready_o  = ~q_full_i;
  assign accept      = in_valid_i & in_ready_o;
  assign hex         = hcilp_pkg::hex_decode(ch_i);
  assign blank       = hcilp_pkg::is_blank(ch_i);
  assign push_o      = accept & emit;
  assign push_item_o = item;

  always_comb begin
    state_d   = state_q;
    resume_d  = resume_q;
    count_d   = count_q;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    off_d     = off_q;
    err_d     = err_q;
    err_off_d = err_off_q;
    msg_d     = msg_q;
    icon_d    = icon_q;
    emit      = 1'b0;

    item          = '0;
    item.kind     = hcilp_pkg::KIND_ICON;
    item.data     = ch_i;
    item.status   = hcilp_pkg::STAT_OK_MSG;
    item.red      = red_q;
    item.green    = green_q;
    item.blue     = blue_q;
    item.channels = count_q;
    item.has_icon = icon_q;

    if (ch_i == hcilp_pkg::ChNul) begin
      emit      = 1'b1;
      item.kind = hcilp_pkg::KIND_DONE;
      item.data = 8'd0;
      if (msg_q) begin
        item.status = hcilp_pkg::STAT_OK_MSG;
      end else if (err_q) begin
        item.status = hcilp_pkg::STAT_ERR;
        item.pos    = err_off_q;
      end else if (state_q == hcilp_pkg::ST_START ||
                   (count_q == hcilp_pkg::ChanMax &&
                    (state_q == hcilp_pkg::ST_HIGH || state_q == hcilp_pkg::ST_BARE))) begin
        item.status = hcilp_pkg::STAT_OK_NOMSG;
      end else begin
        item.status = hcilp_pkg::STAT_ERR;
        item.pos    = off_q;
      end
      state_d   = hcilp_pkg::ST_START;
      resume_d  = hcilp_pkg::RES_BARE;
      count_d   = 2'd0;
      red_d     = 8'd0;
      green_d   = 8'd0;
      blue_d    = 8'd0;
      off_d     = '0;
      err_d     = 1'b0;
      err_off_d = '0;
      msg_d     = 1'b0;
      icon_d    = 1'b0;
    end else begin
      if (err_q) begin
        // drop until terminator
      end else if (msg_q) begin
        emit      = 1'b1;
        item.kind = hcilp_pkg::KIND_MSG;
      end else begin
        case (state_q)
          hcilp_pkg::ST_START: begin
            if (!blank && ch_i != hcilp_pkg::ChHash) begin
              if (!hex[4]) begin
                err_d     = 1'b1;
                err_off_d = off_q;
              end else begin
                red_d   = {hex[3:0], 4'd0};
                state_d = hcilp_pkg::ST_LOW;
              end
            end
          end
          hcilp_pkg::ST_LOW: begin
            if (!hex[4]) begin
              err_d     = 1'b1;
              err_off_d = off_q;
            end else begin
              case (count_q)
                2'd0:    red_d   = red_q | {4'd0, hex[3:0]};
                2'd1:    green_d = green_q | {4'd0, hex[3:0]};
                2'd2:    blue_d  = blue_q | {4'd0, hex[3:0]};
                default: red_d   = red_q;
              endcase
              count_d = count_q + 2'd1;
              state_d = hcilp_pkg::ST_HIGH;
            end
          end
          hcilp_pkg::ST_HIGH: begin
            if (ch_i == hcilp_pkg::ChColon) begin
              if (count_q == hcilp_pkg::ChanMax) begin
                icon_d  = 1'b1;
                state_d = hcilp_pkg::ST_ICON;
              end else begin
                err_d     = 1'b1;
                err_off_d = off_q;
              end
            end else if (blank) begin
              state_d = hcilp_pkg::ST_MSG;
            end else if (!hex[4] || count_q == hcilp_pkg::ChanMax) begin
              err_d     = 1'b1;
              err_off_d = off_q;
            end else begin
              case (count_q)
                2'd1:    green_d = {hex[3:0], 4'd0};
                2'd2:    blue_d  = {hex[3:0], 4'd0};
                default: red_d   = {hex[3:0], 4'd0};
              endcase
              state_d = hcilp_pkg::ST_LOW;
            end
          end
          hcilp_pkg::ST_ICON: begin
            if (ch_i == hcilp_pkg::ChDq) begin
              state_d = hcilp_pkg::ST_DQ;
            end else if (ch_i == hcilp_pkg::ChSq) begin
              state_d = hcilp_pkg::ST_SQ;
            end else begin
              state_d = hcilp_pkg::ST_BARE;
              emit    = 1'b1;
            end
          end
          hcilp_pkg::ST_DQ, hcilp_pkg::ST_SQ: begin
            if ((state_q == hcilp_pkg::ST_DQ && ch_i == hcilp_pkg::ChDq) ||
                (state_q == hcilp_pkg::ST_SQ && ch_i == hcilp_pkg::ChSq)) begin
              state_d = hcilp_pkg::ST_MSG;
            end else if (ch_i == hcilp_pkg::ChBsl) begin
              resume_d = (state_q == hcilp_pkg::ST_DQ) ? hcilp_pkg::RES_DQ
                                                       : hcilp_pkg::RES_SQ;
              state_d  = hcilp_pkg::ST_ESC;
            end else begin
              emit = 1'b1;
            end
          end
          hcilp_pkg::ST_BARE: begin
            if (blank) begin
              state_d = hcilp_pkg::ST_MSG;
            end else if (ch_i == hcilp_pkg::ChBsl) begin
              resume_d = hcilp_pkg::RES_BARE;
              state_d  = hcilp_pkg::ST_ESC;
            end else begin
              emit = 1'b1;
            end
          end
          hcilp_pkg::ST_ESC: begin
            emit = 1'b1;
            case (resume_q)
              hcilp_pkg::RES_DQ: state_d = hcilp_pkg::ST_DQ;
              hcilp_pkg::RES_SQ: state_d = hcilp_pkg::ST_SQ;
              default:           state_d = hcilp_pkg::ST_BARE;
            endcase
          end
          hcilp_pkg::ST_MSG: begin
            if (!blank) begin
              msg_d     = 1'b1;
              emit      = 1'b1;
              item.kind = hcilp_pkg::KIND_MSG;
            end
          end
          default: begin
            err_d     = 1'b1;
            err_off_d = off_q;
          end
        endcase
      end
      if (off_q < hcilp_pkg::PosMax) begin
        off_d = off_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hcilp_pkg::ST_START;
      resume_q  <= hcilp_pkg::RES_BARE;
      count_q   <= 2'd0;
      red_q     <= 8'd0;
      green_q   <= 8'd0;
      blue_q    <= 8'd0;
      off_q     <= '0;
      err_q     <= 1'b0;
      err_off_q <= '0;
      msg_q     <= 1'b0;
      icon_q    <= 1'b0;
    end else if (accept) begin
      state_q   <= state_d;
      resume_q  <= resume_d;
      count_q   <= count_d;
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      off_q     <= off_d;
      err_q     <= err_d;
      err_off_q <= err_off_d;
      msg_q     <= msg_d;
      icon_q    <= icon_d;
    end
  end

endmodule

// File: rtl/hcilp_queue.sv
// ----------------------------------------------------------------------------
// hcilp_queue
// Short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module hcilp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hcilp_pkg::item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             nonempty_o,
  output hcilp_pkg::item_t head_o
);

  hcilp_pkg::item_t               mem_q [hcilp_pkg::QDepth];
  logic [hcilp_pkg::QPtrW-1:0]    wr_q, rd_q;
  logic [hcilp_pkg::QCntW-1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == hcilp_pkg::QCntW'(hcilp_pkg::QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/hcilp_back.sv
// ----------------------------------------------------------------------------
// hcilp_back
// Output stage: takes queued transactions, formats the result fields and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
module hcilp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       nonempty_i,
  input  hcilp_pkg::item_t           head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 data_o,
  output logic [1:0]                 status_o,
  output logic [hcilp_pkg::PosW-1:0] error_pos_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [1:0]                 channels_o,
  output logic                       has_icon_o
);

  logic             valid_q;
  hcilp_pkg::item_t out_q, out_d;

  assign pop_o = nonempty_i & (~valid_q | out_ready_i);

  always_comb begin
    out_d = head_i;
    if (head_i.kind == hcilp_pkg::KIND_DONE) begin
      out_d.data = 8'd0;
    end else begin
      out_d.status   = hcilp_pkg::STAT_OK_MSG;
      out_d.pos      = '0;
      out_d.red      = 8'd0;
      out_d.green    = 8'd0;
      out_d.blue     = 8'd0;
      out_d.channels = 2'd0;
      out_d.has_icon = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = out_q.kind;
  assign data_o      = out_q.data;
  assign status_o    = out_q.status;
  assign error_pos_o = out_q.pos;
  assign red_o       = out_q.red;
  assign green_o     = out_q.green;
  assign blue_o      = out_q.blue;
  assign channels_o  = out_q.channels;
  assign has_icon_o  = out_q.has_icon;

endmodule

// File: rtl/hex_color_icon_line_parser.sv
// ----------------------------------------------------------------------------
// hex_color_icon_line_parser
// Streaming parser for a colour, icon and message line, one character per
// transaction, emitting icon bytes, message bytes and a done summary.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------
//  input   | in_valid_i / in_ready_o     | ch_i
//  output  | out_valid_o / out_ready_i   | kind_o data_o status_o error_pos_o
//          |                             | red_o green_o blue_o channels_o
//          |                             | has_icon_o
//
//  One character per cycle while the queue is not full; the parser state
//  updates in the cycle it is taken. A result is written into the queue when
//  its character is taken, then into the output register once that is free.
//  The four-entry queue lets the parser run while the output stalls;
//  input ready drops only when the queue is full.
//  Reset clears the line state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module hex_color_icon_line_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 ch_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 data_o,
  output logic [1:0]                 status_o,
  output logic [hcilp_pkg::PosW-1:0] error_pos_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [1:0]                 channels_o,
  output logic                       has_icon_o
);

  logic             push, full, pop, nonempty;
  hcilp_pkg::item_t push_item, head;

  hcilp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  hcilp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .head_o      (head)
  );

  hcilp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .status_o    (status_o),
    .error_pos_o (error_pos_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .channels_o  (channels_o),
    .has_icon_o  (has_icon_o)
  );

endmodule

// File: rtl/hcilp_checker.sv
// ----------------------------------------------------------------------------
// hcilp_checker
// Port-level checks on the line parser's result transactions.
// ----------------------------------------------------------------------------
module hcilp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 kind_o,
  input logic [7:0]                 data_o,
  input logic [1:0]                 status_o,
  input logic [hcilp_pkg::PosW-1:0] error_pos_o,
  input logic [7:0]                 red_o,
  input logic [7:0]                 green_o,
  input logic [7:0]                 blue_o,
  input logic [1:0]                 channels_o,
  input logic                       has_icon_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(data_o))
    else $error("result changed while stalled");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != hcilp_pkg::KIND_DONE |->
      status_o == 2'd0 && error_pos_o == '0 && red_o == 8'd0 && green_o == 8'd0 &&
      blue_o == 8'd0 && channels_o == 2'd0 && !has_icon_o)
    else $error("summary fields set on byte transaction");

  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == hcilp_pkg::KIND_DONE |->
      data_o == 8'd0 && (status_o == hcilp_pkg::STAT_ERR || error_pos_o == '0))
    else $error("done transaction carries data or stray offset");

  a_icon_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == hcilp_pkg::KIND_DONE && has_icon_o |->
      channels_o == hcilp_pkg::ChanMax)
    else $error("icon reported without three channels");

endmodule

bind hex_color_icon_line_parser hcilp_checker u_hcilp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .data_o      (data_o),
  .status_o    (status_o),
  .error_pos_o (error_pos_o),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .channels_o  (channels_o),
  .has_icon_o  (has_icon_o)
);
